FILE: rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and helpers for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  // One queued input word
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_item_t;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Initial chaining values
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // Padding marker byte and position where the length field starts
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'h3f;
  localparam logic [5:0] LAST_STEP  = 6'h3f;

  // Additive constants of the 64 steps
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amount for a given round and step-within-four
  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] sub);
    logic [4:0] s;
    s = 5'd7;
    case (rnd)
      2'd0: case (sub)
              2'd0: s = 5'd7;
              2'd1: s = 5'd12;
              2'd2: s = 5'd17;
              default: s = 5'd22;
            endcase
      2'd1: case (sub)
              2'd0: s = 5'd5;
              2'd1: s = 5'd9;
              2'd2: s = 5'd14;
              default: s = 5'd20;
            endcase
      2'd2: case (sub)
              2'd0: s = 5'd4;
              2'd1: s = 5'd11;
              2'd2: s = 5'd16;
              default: s = 5'd23;
            endcase
      default: case (sub)
              2'd0: s = 5'd6;
              2'd1: s = 5'd10;
              2'd2: s = 5'd15;
              default: s = 5'd21;
            endcase
    endcase
    return s;
  endfunction

  // Reverse byte order of a word (digest bytes leave low byte first)
  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

FILE: rtl/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front
// Input side: accepts words, drops items with no byte and no end mark,
// and queues the rest for the compression engine.
// ----------------------------------------------------------------------------
module md5_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] message_byte
  input  logic [0:0]          in_tuser,   // [0] byte_present
  input  logic                in_tlast,   // end_of_message
  output logic                q_valid,
  output md5_pkg::md5_item_t  q_item,
  input  logic                q_ready
);

  localparam int unsigned PTR_W = (md5_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(md5_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(md5_pkg::QUEUE_DEPTH + 1);

  md5_pkg::md5_item_t queue_r [md5_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;
  logic               useful;

  // Classify: an item with neither byte nor end changes nothing
  assign useful    = in_tuser[0] | in_tlast;
  assign in_tready = (count_r != CNT_W'(md5_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid & in_tready & useful;
  assign pop       = q_valid & q_ready;
  assign q_valid   = (count_r != '0);
  assign q_item    = queue_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(md5_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(md5_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store queued words
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{message_byte:   in_tdata,
                             byte_present:   in_tuser[0],
                             end_of_message: in_tlast};
    end
  end

endmodule

FILE: rtl/md5_core.sv
// ----------------------------------------------------------------------------
// md5_core
// Back end: packs bytes into the block, pads the final block, runs the
// 64-step compression one step per cycle and emits the digest halves.
// ----------------------------------------------------------------------------
module md5_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  md5_pkg::md5_item_t  q_item,
  output logic                q_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,  // [63:0] digest_half
  output logic [0:0]          out_tuser,  // [0] half_index
  output logic                out_tlast   // last_half
);

  typedef enum logic [2:0] {
    S_LOAD, S_PAD, S_COMP, S_ADD, S_OUT0, S_OUT1
  } state_t;

  state_t      state_r;
  state_t      ret_r;
  logic [31:0] chain_r [4];
  logic [31:0] block_r [16];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] bit_count_r;
  logic [5:0]  fill_r;
  logic [5:0]  step_r;
  logic        pad_first_r;
  logic        len_mode_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_half_r;

  logic        take;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [5:0]  fill_nxt;
  logic        out_free;
  logic        out_set;
  logic [1:0]  rnd;
  logic [3:0]  k;
  logic [3:0]  widx;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] b_nxt;

  assign q_ready    = (state_r == S_LOAD);
  assign take       = q_valid & q_ready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_set    = out_free & ((state_r == S_OUT0) | (state_r == S_OUT1));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_half_r;
  assign out_tlast  = out_half_r;

  // Select the byte that goes into the block this cycle
  always_comb begin
    put_en   = 1'b0;
    put_byte = 8'h00;
    if (state_r == S_LOAD) begin
      put_en   = take & q_item.byte_present;
      put_byte = q_item.message_byte;
    end else if (state_r == S_PAD) begin
      put_en = 1'b1;
      if (pad_first_r) begin
        put_byte = md5_pkg::PAD_MARK;
      end else if (len_mode_r) begin
        put_byte = bit_count_r[{fill_r[2:0], 3'b000} +: 8];
      end
    end
  end

  assign fill_nxt = fill_r + 1'b1;

  // Step function and message word index
  assign rnd = step_r[5:4];
  assign k   = step_r[3:0];

  always_comb begin
    case (rnd)
      2'd0: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        widx  = k;
      end
      2'd1: begin
        f_val = (b_r & d_r) | (c_r & ~d_r);
        widx  = 4'(k * 4'd5 + 4'd1);
      end
      2'd2: begin
        f_val = b_r ^ c_r ^ d_r;
        widx  = 4'(k * 4'd3 + 4'd5);
      end
      default: begin
        f_val = c_r ^ (b_r | ~d_r);
        widx  = 4'(k * 4'd7);
      end
    endcase
  end

  assign sum      = a_r + f_val + md5_pkg::ROUND_K[step_r] + block_r[widx];
  assign rot_wide = {sum, sum} << md5_pkg::rot_amount(rnd, step_r[1:0]);
  assign b_nxt    = b_r + rot_wide[63:32];

  // Write message bytes into their lanes
  always_ff @(posedge clk) begin
    if (put_en) begin
      block_r[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] <= put_byte;
    end
  end

  // Sequencer, chaining state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ret_r       <= S_LOAD;
      chain_r[0]  <= md5_pkg::INIT_A;
      chain_r[1]  <= md5_pkg::INIT_B;
      chain_r[2]  <= md5_pkg::INIT_C;
      chain_r[3]  <= md5_pkg::INIT_D;
      bit_count_r <= '0;
      fill_r      <= '0;
      step_r      <= '0;
      pad_first_r <= 1'b0;
      len_mode_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a new digest half, drop it once taken
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (put_en) begin
        fill_r <= fill_nxt;
      end
      unique case (state_r)
        S_LOAD: begin
          if (take) begin
            if (q_item.byte_present) begin
              bit_count_r <= bit_count_r + 64'd8;
            end
            pad_first_r <= 1'b1;
            if (q_item.byte_present && fill_r == md5_pkg::LAST_POS) begin
              state_r <= S_COMP;
              ret_r   <= q_item.end_of_message ? S_PAD : S_LOAD;
            end else if (q_item.end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first_r <= 1'b0;
          // Length field begins once padding reaches byte 56
          if (!len_mode_r && fill_nxt == md5_pkg::LEN_START) begin
            len_mode_r <= 1'b1;
          end
          if (fill_r == md5_pkg::LAST_POS) begin
            state_r <= S_COMP;
            ret_r   <= len_mode_r ? S_OUT0 : S_PAD;
          end
        end
        S_COMP: begin
          a_r    <= d_r;
          d_r    <= c_r;
          c_r    <= b_r;
          b_r    <= b_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == md5_pkg::LAST_STEP) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          state_r    <= ret_r;
        end
        S_OUT0: begin
          if (out_free) begin
            out_data_r  <= {md5_pkg::byte_swap(chain_r[0]), md5_pkg::byte_swap(chain_r[1])};
            out_half_r  <= 1'b0;
            state_r     <= S_OUT1;
          end
        end
        S_OUT1: begin
          if (out_free) begin
            out_data_r  <= {md5_pkg::byte_swap(chain_r[2]), md5_pkg::byte_swap(chain_r[3])};
            out_half_r  <= 1'b1;
            // Drop back to the initial values for the next message
            chain_r[0]  <= md5_pkg::INIT_A;
            chain_r[1]  <= md5_pkg::INIT_B;
            chain_r[2]  <= md5_pkg::INIT_C;
            chain_r[3]  <= md5_pkg::INIT_D;
            bit_count_r <= '0;
            fill_r      <= '0;
            len_mode_r  <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
      // Load working words from the chaining state when a compression starts
      if (state_r != S_COMP && state_r != S_ADD) begin
        a_r    <= chain_r[0];
        b_r    <= chain_r[1];
        c_r    <= chain_r[2];
        d_r    <= chain_r[3];
        step_r <= '0;
      end
    end
  end

endmodule

FILE: rtl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one byte per input word, digest as two
// 64-bit halves.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the engine loads; then, for each full
//   64-byte block, 64 compression steps on one shared step unit and one add.
// End of message: one padding byte per cycle (9 to 72) plus one or two more
//   compressions, then the two digest halves in order, each held until taken.
// Input words are registered in the two-entry input queue before the engine.
// Reset: synchronous, active low; chaining words to the initial values, bit
//   count and fill position to zero; no clearing pass.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic [0:0]  in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_half
  output logic [0:0]  out_tuser,  // [0] half_index
  output logic        out_tlast   // last_half
);

  logic               q_valid;
  logic               q_ready;
  md5_pkg::md5_item_t q_item;

  // Accept and queue words
  md5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  // Pack, pad, compress and emit the digest
  md5_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md5_message_digest: byte messages of varied length
// go in through bursty input traffic, and each pair of digest halves is
// compared with an independent MD5 computation while the output side stalls.
// ----------------------------------------------------------------------------
module tb;

  // Expected digest word
  typedef struct {
    logic [63:0] digest;
    logic        half_idx;
    logic        is_last;
  } digest_word_t;

  localparam int unsigned TARGET_ITEMS = 850;

  // Additive constants of the 64 MD5 steps
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, four per round
  localparam int SHIFT_TAB [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] message_byte
  logic [0:0]  in_tuser = 1'b0;    // [0] byte_present
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;          // [63:0] digest_half
  logic [0:0]  out_tuser;          // [0] half_index
  logic        out_tlast;          // last_half

  md5_message_digest DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [31:0] chain_w [4];
  logic [31:0] block_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  md5_pkg::md5_item_t byte_q [$];
  digest_word_t       digest_q [$];

  int errors = 0;
  int items_counted = 0;
  int messages = 0;
  int msg_bytes = 0;
  int longest_msg = 0;
  int digests_checked = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cycle_cnt = 0;
  bit hold_word;
  bit ready_next;

  function automatic void md5_restart();
    chain_w[0] = 32'h67452301;
    chain_w[1] = 32'hefcdab89;
    chain_w[2] = 32'h98badcfe;
    chain_w[3] = 32'h10325476;
    for (int i = 0; i < 16; i++) block_w[i] = 32'h0;
    msg_bits = 64'h0;
    fill_pos = 6'd0;
  endfunction

  // Fold one full block into the chaining words
  function automatic void md5_fold_block();
    logic [31:0] a, b, c, d, f, keep, sum;
    int rnd, g, sh;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int s = 0; s < 64; s++) begin
      rnd = s / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = s % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * s + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * s + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * s) % 16;
        end
      endcase
      sh = SHIFT_TAB[rnd * 4 + s % 4];
      sum = a + f + SINE_K[s] + block_w[g];
      keep = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
      a = keep;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endfunction

  // Place a byte little-endian in the block, compress when full
  function automatic void md5_load_byte(input logic [7:0] b);
    int word, lane;
    word = fill_pos / 4;
    lane = fill_pos % 4;
    if (lane == 0) block_w[word] = {24'h0, b};
    else block_w[word][8 * lane +: 8] = b;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) md5_fold_block();
  endfunction

  // Absorb one accepted word; on end of message queue both digest halves
  function automatic void md5_absorb_item(input md5_pkg::md5_item_t it);
    logic [63:0] len, v;
    logic [31:0] w;
    digest_word_t dw;
    if (it.byte_present) begin
      md5_load_byte(it.message_byte);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.end_of_message) begin
      len = msg_bits;
      md5_load_byte(8'h80);
      while (fill_pos != 6'd56) md5_load_byte(8'h00);
      for (int i = 0; i < 8; i++) md5_load_byte(len[8 * i +: 8]);
      for (int h = 0; h < 2; h++) begin
        v = 64'h0;
        for (int i = 0; i < 8; i++) begin
          w = chain_w[2 * h + i / 4];
          v = {v[55:0], w[8 * (i % 4) +: 8]};
        end
        dw.digest = v;
        dw.half_idx = h[0];
        dw.is_last = h[0];
        digest_q.push_back(dw);
      end
      md5_restart();
    end
  endfunction

  function automatic void queue_word(input logic [7:0] b, input bit present, input bit eom);
    md5_pkg::md5_item_t it;
    it.message_byte = b;
    it.byte_present = present;
    it.end_of_message = eom;
    byte_q.push_back(it);
    if (present || eom) items_counted++;
  endfunction

  // Queue one message; end either on its last byte or with a separate empty word
  function automatic void queue_message(input int len, input bit end_apart);
    bit apart;
    apart = end_apart || (len == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_word(8'($urandom_range(0, 255)), 1'b1, !apart && (i == len - 1));
    end
    if (apart) queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    messages++;
    msg_bytes += len;
    if (len > longest_msg) longest_msg = len;
  endfunction

  // Driver: present queued words in bursts separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      hold_word = 1'b0;
      if (in_tvalid && in_tready) md5_absorb_item(byte_q.pop_front());
      else hold_word = in_tvalid;
      if (!hold_word) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
          in_tvalid <= 1'b1;
          in_tdata <= byte_q[0].message_byte;
          in_tuser <= byte_q[0].byte_present;
          in_tlast <= byte_q[0].end_of_message;
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each digest word, stall on a pattern that changes mode
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %0d", $time,
                   out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          digest_word_t exp_w;
          exp_w = digest_q.pop_front();
          digests_checked++;
          if (out_tdata !== exp_w.digest) begin
            $display("%0t: digest_half expected %h actual %h", $time,
                     exp_w.digest, out_tdata);
            errors++;
          end
          if (out_tuser[0] !== exp_w.half_idx) begin
            $display("%0t: half_index expected %0d actual %0d", $time,
                     exp_w.half_idx, out_tuser[0]);
            errors++;
          end
          if (out_tlast !== exp_w.is_last) begin
            $display("%0t: last_half expected %0d actual %0d", $time,
                     exp_w.is_last, out_tlast);
            errors++;
          end
        end
      end
      case ((cycle_cnt >> 7) & 3)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 9) < 7);
        2: ready_next = (cycle_cnt % 5 != 0);
        default: ready_next = ($urandom_range(0, 9) < 3);
      endcase
      out_tready <= ready_next;
    end
  end

  // Stimulus and end of run
  initial begin
    int len, pick;
    int edge_lens [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    md5_restart();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message
    queue_word(8'h00, 1'b0, 1'b1);
    // Idle word, then single bytes at both extremes
    queue_word(8'ha5, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b1);
    queue_word(8'hff, 1'b1, 1'b1);
    // "abc" ending on its last byte
    queue_word(8'h61, 1'b1, 1'b0);
    queue_word(8'h62, 1'b1, 1'b0);
    queue_word(8'h63, 1'b1, 1'b1);
    // Bytes, then an end word carrying no byte
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'h5a, 1'b1, 1'b0);
    queue_word(8'h3c, 1'b0, 1'b1);
    // Idle word, then empty message again
    queue_word(8'hff, 1'b0, 1'b0);
    queue_word(8'hc3, 1'b0, 1'b1);
    messages += 6;
    msg_bytes += 8;
    longest_msg = 3;

    // Random messages, lengths biased to padding boundaries and short sizes
    while (items_counted < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) len = edge_lens[$urandom_range(0, 11)];
      else if (pick == 3) len = $urandom_range(100, 200);
      else len = $urandom_range(0, 40);
      queue_message(len, $urandom_range(0, 1));
    end

    wait (byte_q.size() == 0 && !in_tvalid);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);

    $display("Covered %0d messages, %0d message bytes (longest %0d), %0d digest words checked.",
             messages, msg_bytes, longest_msg, digests_checked);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Timeout with %0d words pending and %0d digest words outstanding.",
             byte_q.size(), digest_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
